// ===== sv/crx_pkg.sv =====
`timescale 1ns / 1ps

package crx_pkg;

  localparam int WIN_DEPTH = 64;
  localparam int WIN_AW    = 6;
  localparam int QDEPTH    = 4;
  localparam int QAW       = 2;
  localparam int OUT_DEPTH = 2;

  // one window entry: received byte and running sum through that byte
  typedef struct packed {
    logic [7:0] sum;
    logic [7:0] data;
  } win_word_t;

  // accepted frame: window address of first payload byte, payload length
  typedef struct packed {
    logic [WIN_AW-1:0] start;
    logic [5:0]        len;
  } desc_t;

  // oldest window entry the back end still has to read
  typedef struct packed {
    logic              pend;
    logic [WIN_AW-1:0] oldest;
  } back_status_t;

endpackage

// ===== sv/crx_window.sv =====
`timescale 1ns / 1ps

module crx_window (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [crx_pkg::WIN_AW-1:0]  wr_addr,
  input  crx_pkg::win_word_t          wr_data,
  input  logic [crx_pkg::WIN_AW-1:0]  rd_a_addr,
  output crx_pkg::win_word_t          rd_a_data,
  input  logic [crx_pkg::WIN_AW-1:0]  rd_b_addr,
  output crx_pkg::win_word_t          rd_b_data
);

  crx_pkg::win_word_t mem [crx_pkg::WIN_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ===== sv/crx_front.sv =====
`timescale 1ns / 1ps

module crx_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
  input  logic [5:0]                  payload_eff,
  input  logic [7:0]                  head_byte,
  input  logic [7:0]                  tail_byte,
  input  logic [crx_pkg::QAW:0]       q_count,
  input  crx_pkg::back_status_t       back_st,
  output logic                        wr_en,
  output logic [crx_pkg::WIN_AW-1:0]  wr_addr,
  output crx_pkg::win_word_t          wr_data,
  output logic [crx_pkg::WIN_AW-1:0]  chk_addr,
  input  crx_pkg::win_word_t          chk_data,
  output logic                        push,
  output crx_pkg::desc_t              push_desc
);

  logic [crx_pkg::WIN_AW-1:0] wr_ptr;
  logic [6:0]                 fill_count;
  logic [6:0]                 fill_next;
  logic [6:0]                 skip_count;
  logic [6:0]                 frame_len;
  logic [7:0]                 prev_byte;
  logic [7:0]                 cum_d1;
  logic [7:0]                 cum_d2;
  logic [7:0]                 cum_new;
  logic                       clobber;
  logic                       accept;

  // check stage
  logic                       s1_valid;
  logic [7:0]                 s1_b0;
  logic [7:0]                 s1_b1;
  logic [7:0]                 s1_c2;
  logic                       s1_fill_ok;
  crx_pkg::desc_t             s1_desc;
  logic                       head_ok;
  logic                       tail_ok;
  logic                       sum_ok;
  logic                       check_ok;

  assign clobber   = back_st.pend && (back_st.oldest == wr_ptr);
  assign s_tready  = !clobber &&
                     ((q_count + (crx_pkg::QAW+1)'(s1_valid)) <
                      (crx_pkg::QAW+1)'(crx_pkg::QDEPTH));
  assign accept    = s_tvalid && s_tready;

  assign frame_len = {1'b0, payload_eff} + 7'd3;
  assign fill_next = (fill_count == 7'(crx_pkg::WIN_DEPTH)) ? fill_count
                                                            : fill_count + 7'd1;
  assign cum_new   = cum_d1 + s_tdata;

  assign wr_en        = accept;
  assign wr_addr      = wr_ptr;
  assign wr_data.sum  = cum_new;
  assign wr_data.data = s_tdata;
  // entry holding the head byte of the candidate ending at this byte
  assign chk_addr     = wr_ptr - (payload_eff + 6'd2);

  assign head_ok  = chk_data.data == head_byte;
  assign tail_ok  = s1_b0 == tail_byte;
  assign sum_ok   = (s1_c2 - chk_data.sum) == s1_b1;
  assign check_ok = s1_fill_ok && head_ok && tail_ok && sum_ok;

  assign push      = s1_valid && (skip_count == 7'd0) && check_ok;
  assign push_desc = s1_desc;

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_byte     <= s_tdata;
      s1_b0         <= s_tdata;
      s1_b1         <= prev_byte;
      s1_c2         <= cum_d2;
      s1_fill_ok    <= fill_next >= frame_len;
      s1_desc.start <= wr_ptr - (payload_eff + 6'd1);
      s1_desc.len   <= payload_eff;
    end
    if (rst) begin
      wr_ptr     <= '0;
      fill_count <= '0;
      skip_count <= '0;
      s1_valid   <= 1'b0;
      cum_d1     <= '0;
      cum_d2     <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        wr_ptr     <= wr_ptr + 1'b1;
        fill_count <= fill_next;
        cum_d1     <= cum_new;
        cum_d2     <= cum_d1;
      end
      if (s1_valid) begin
        if (skip_count != 7'd0) begin
          skip_count <= skip_count - 7'd1;
        end else if (check_ok) begin
          skip_count <= {1'b0, s1_desc.len} + 7'd2;
        end
      end
    end
  end

endmodule

// ===== sv/crx_queue.sv =====
`timescale 1ns / 1ps

module crx_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  crx_pkg::desc_t        push_desc,
  input  logic                  pop,
  output logic                  head_valid,
  output crx_pkg::desc_t        head,
  output logic [crx_pkg::QAW:0] count
);

  crx_pkg::desc_t             slots [crx_pkg::QDEPTH];
  logic [crx_pkg::QAW-1:0]    wr_ptr;
  logic [crx_pkg::QAW-1:0]    rd_ptr;

  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (crx_pkg::QAW+1)'(push) - (crx_pkg::QAW+1)'(pop);
    end
  end

endmodule

// ===== sv/crx_back.sv =====
`timescale 1ns / 1ps

module crx_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  crx_pkg::desc_t              q_head,
  output logic                        q_pop,
  output logic [crx_pkg::WIN_AW-1:0]  rd_addr,
  input  crx_pkg::win_word_t          rd_data,
  output crx_pkg::back_status_t       status,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // [7:0] payload_byte, [13:8] byte_position
  output logic                        m_tlast    // last_of_frame
);

  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic       last;
  } out_entry_t;

  logic                       active;
  logic [crx_pkg::WIN_AW-1:0] cur_addr;
  logic [5:0]                 cur_pos;
  logic [5:0]                 cur_last_pos;
  logic                       rd_pend;
  logic [5:0]                 pend_pos;
  logic                       pend_last;

  out_entry_t                 obuf [crx_pkg::OUT_DEPTH];
  logic                       o_wr;
  logic                       o_rd;
  logic [1:0]                 o_count;
  logic [1:0]                 o_level;
  logic                       pop;
  logic                       issue;
  out_entry_t                 o_head;

  assign q_pop   = !active && q_valid;
  assign rd_addr = cur_addr;

  assign status.pend   = active || q_valid;
  assign status.oldest = active ? cur_addr : q_head.start;

  assign o_head   = obuf[o_rd];
  assign m_tvalid = o_count != 2'd0;
  assign m_tdata  = {2'b00, o_head.pos, o_head.data};
  assign m_tlast  = o_head.last;
  assign pop      = m_tvalid && m_tready;

  // reads in flight plus entries held never exceed the output buffer
  assign o_level = o_count + {1'b0, rd_pend};
  assign issue   = active && ((o_level < 2'(crx_pkg::OUT_DEPTH)) || pop);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_addr     <= q_head.start;
      cur_pos      <= '0;
      cur_last_pos <= q_head.len - 6'd1;
    end else if (issue) begin
      cur_addr <= cur_addr + 1'b1;
      cur_pos  <= cur_pos + 6'd1;
    end
    if (issue) begin
      pend_pos  <= cur_pos;
      pend_last <= cur_pos == cur_last_pos;
    end
    if (rd_pend) begin
      obuf[o_wr] <= '{data: rd_data.data, pos: pend_pos, last: pend_last};
    end
    if (rst) begin
      active  <= 1'b0;
      rd_pend <= 1'b0;
      o_count <= '0;
      o_wr    <= 1'b0;
      o_rd    <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
      end else if (issue && (cur_pos == cur_last_pos)) begin
        active <= 1'b0;
      end
      rd_pend <= issue;
      if (rd_pend) begin
        o_wr <= !o_wr;
      end
      if (pop) begin
        o_rd <= !o_rd;
      end
      o_count <= o_count + {1'b0, rd_pend} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/checked_frame_receiver.sv =====
`timescale 1ns / 1ps
// Channel  | Signals                            | Carries
// ---------+------------------------------------+----------------------------------------
// s_       | s_tvalid s_tready s_tdata[7:0]     | rx_byte
// m_       | m_tvalid m_tready m_tdata[15:0]    | payload_byte, byte_position; m_tlast
// apb      | psel penable pwrite paddr pwdata   | payload_len @0, head_byte @4,
//          | prdata pready                      | tail_byte @8
//
// One received byte per cycle while s_tready is high; the check result comes in the cycle
// after the byte. Payload bytes leave at one per cycle while m_tready is high, from the
// window memory's second read port after the frame queue, with a load step per frame.
// s_tready drops while the next window write would overwrite a payload byte not yet
// read out, or while the frame queue has no room. Reset: rst, synchronous.
// The window memory is not cleared; the fill count guards against stale entries.

module checked_frame_receiver #(
  parameter int MAX_PAYLOAD = 61
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // [7:0] payload_byte, [13:8] byte_position
  output logic        m_tlast,    // last_of_frame
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    REG_PAYLOAD_LEN = 2'd0,
    REG_HEAD_BYTE   = 2'd1,
    REG_TAIL_BYTE   = 2'd2
  } reg_idx_t;

  logic [5:0]                 payload_len;
  logic [7:0]                 head_byte;
  logic [7:0]                 tail_byte;
  logic [5:0]                 payload_eff;
  logic                       cfg_wr;
  reg_idx_t                   cfg_idx;

  logic                       wr_en;
  logic [crx_pkg::WIN_AW-1:0] wr_addr;
  crx_pkg::win_word_t         wr_data;
  logic [crx_pkg::WIN_AW-1:0] chk_addr;
  crx_pkg::win_word_t         chk_data;
  logic [crx_pkg::WIN_AW-1:0] rd_addr;
  crx_pkg::win_word_t         rd_data;
  logic                       q_push;
  crx_pkg::desc_t             q_push_desc;
  logic                       q_pop;
  logic                       q_valid;
  crx_pkg::desc_t             q_head;
  logic [crx_pkg::QAW:0]      q_count;
  crx_pkg::back_status_t      back_st;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_PAYLOAD_LEN: prdata = {26'd0, payload_len};
      REG_HEAD_BYTE:   prdata = {24'd0, head_byte};
      REG_TAIL_BYTE:   prdata = {24'd0, tail_byte};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_len <= 6'd16;
      head_byte   <= 8'hA5;
      tail_byte   <= 8'h5A;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PAYLOAD_LEN: payload_len <= pwdata[5:0];
        REG_HEAD_BYTE:   head_byte   <= pwdata[7:0];
        REG_TAIL_BYTE:   tail_byte   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign payload_eff = (payload_len == 6'd0)              ? 6'd1 :
                       (payload_len > 6'(MAX_PAYLOAD))    ? 6'(MAX_PAYLOAD) :
                                                            payload_len;

  crx_window u_window (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (chk_addr),
    .rd_a_data (chk_data),
    .rd_b_addr (rd_addr),
    .rd_b_data (rd_data)
  );

  crx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .payload_eff (payload_eff),
    .head_byte   (head_byte),
    .tail_byte   (tail_byte),
    .q_count     (q_count),
    .back_st     (back_st),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .chk_addr    (chk_addr),
    .chk_data    (chk_data),
    .push        (q_push),
    .push_desc   (q_push_desc)
  );

  crx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (q_push_desc),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head),
    .count      (q_count)
  );

  crx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .status   (back_st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < (crx_pkg::QAW+1)'(crx_pkg::QDEPTH)) || q_pop)
    else $error("frame pushed into a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_count != '0)
    else $error("frame popped from an empty queue");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !q_push && !q_pop |=> $stable(q_count))
    else $error("queue count moved without push or pop");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && !q_valid)
    else $error("output or queue busy after reset");

  a_write_safe: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !(back_st.pend && (back_st.oldest == wr_addr)))
    else $error("window write over an unread payload byte");
`endif

endmodule
